// ===== rtl/lsp_pkg.sv =====
// Package for the line pixel stepper: coordinate widths, stream widths,
// opcodes and the queued command record shared by the front, queue and back.
// No dependencies.
`default_nettype none

package lsp_pkg;

	// Coordinate width and the widths that follow from it.
	localparam int COORD_W = 12;
	localparam int SPY_W   = COORD_W + 1;  // negated y span, two's complement
	localparam int ERR_W   = COORD_W + 2;  // error term, two's complement
	localparam int E2_W    = COORD_W + 3;  // doubled error term

	// Stream payload widths, padded to whole bytes.
	localparam int IN_TDATA_W  = ((4 * COORD_W + 7) / 8) * 8;
	localparam int OUT_TDATA_W = ((2 * COORD_W + 7) / 8) * 8;

	// Command queue between front and back.
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic {
		OP_LOAD = 1'b0,
		OP_STEP = 1'b1
	} opcode_t;

	// One classified request with the line setup already worked out.
	typedef struct packed {
		opcode_t                   opcode;
		logic [COORD_W-1:0]        start_x;
		logic [COORD_W-1:0]        start_y;
		logic [COORD_W-1:0]        end_x;
		logic [COORD_W-1:0]        end_y;
		logic [COORD_W-1:0]        span_x;
		logic signed [SPY_W-1:0]   span_y_neg;
		logic                      step_x_neg;
		logic                      step_y_neg;
		logic signed [ERR_W-1:0]   err_init;
	} cmd_t;

endpackage

`default_nettype wire

// ===== rtl/line_pixel_stepper.sv =====
// Top level of the line pixel stepper: front end, command queue and back end.
// Depends on lsp_pkg, lsp_front, lsp_queue and lsp_back.
//
//   Channel   Direction  Handshake            Payload
//   s_*       in         s_tvalid / s_tready  tdata: start_x, start_y, end_x, end_y; tuser: opcode
//   m_*       out        m_tvalid / m_tready  tdata: pixel_x, pixel_y; tlast: last
//
// One request is taken per cycle while the queue is not full; a step request
// yields its pixel in the cycle after it leaves the two-entry command queue,
// and the sustained rate is one pixel per cycle while the output is not stalled,
// set by the back end's error-term update. Reset clears the line state and the
// queue, leaving the block idle. A stalled output holds a step request at the
// queue head while a line is active; the front keeps accepting until the queue is full.
`default_nettype none

module line_pixel_stepper import lsp_pkg::*; (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   s_tvalid,
	output logic                        s_tready,
	input  wire logic [IN_TDATA_W-1:0]  s_tdata,   // start_x, start_y, end_x, end_y
	input  wire logic                   s_tuser,   // opcode
	output logic                        m_tvalid,
	input  wire logic                   m_tready,
	output logic [OUT_TDATA_W-1:0]      m_tdata,   // pixel_x, pixel_y
	output logic                        m_tlast    // last
);

	cmd_t front_cmd, head_cmd;
	logic q_full, q_push, q_pop, head_valid;

	// Classify and set up incoming requests.
	lsp_front u_front (
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.cmd     (front_cmd)
	);

	assign s_tready = !q_full;
	assign q_push   = s_tvalid && s_tready;

	// Queue between front and back.
	lsp_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_cmd   (front_cmd),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (head_valid),
		.head_cmd   (head_cmd)
	);

	// Line walker and output register.
	lsp_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_cmd   (head_cmd),
		.pop        (q_pop),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tlast    (m_tlast)
	);

endmodule

`default_nettype wire

// ===== rtl/lsp_front.sv =====
// Front end of the line pixel stepper: unpacks the input stream payload and
// computes the line setup (spans, directions, initial error). Uses lsp_pkg.
`default_nettype none

module lsp_front import lsp_pkg::*; (
	input  wire logic [IN_TDATA_W-1:0] s_tdata,   // start_x, start_y, end_x, end_y
	input  wire logic                  s_tuser,   // opcode
	output cmd_t                       cmd
);

	logic [COORD_W-1:0] sx, sy, ex, ey;
	logic [COORD_W-1:0] dx_abs, dy_abs;

	// Field unpacking, first field in the lowest bits.
	assign sx = s_tdata[COORD_W-1:0];
	assign sy = s_tdata[2*COORD_W-1:COORD_W];
	assign ex = s_tdata[3*COORD_W-1:2*COORD_W];
	assign ey = s_tdata[4*COORD_W-1:3*COORD_W];

	// Absolute spans of the line.
	assign dx_abs = (ex >= sx) ? (ex - sx) : (sx - ex);
	assign dy_abs = (ey >= sy) ? (ey - sy) : (sy - ey);

	// Build the queued record; setup fields are ignored on a step.
	always_comb begin
		cmd.opcode     = opcode_t'(s_tuser);
		cmd.start_x    = sx;
		cmd.start_y    = sy;
		cmd.end_x      = ex;
		cmd.end_y      = ey;
		cmd.span_x     = dx_abs;
		cmd.span_y_neg = SPY_W'(0) - {1'b0, dy_abs};
		cmd.step_x_neg = !(sx < ex);
		cmd.step_y_neg = !(sy < ey);
		cmd.err_init   = {2'b00, dx_abs} - {2'b00, dy_abs};
	end

endmodule

`default_nettype wire

// ===== rtl/lsp_queue.sv =====
// Short command queue that decouples the front end from the back end.
// Holds classified requests as cmd_t records. Uses lsp_pkg.
`default_nettype none

module lsp_queue import lsp_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire cmd_t push_cmd,
	output logic      full,
	input  wire logic pop,
	output logic      head_valid,
	output cmd_t      head_cmd
);

	cmd_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
		if (p == QPTR_W'(QUEUE_DEPTH - 1))
			return '0;
		else
			return p + QPTR_W'(1);
	endfunction

	assign full       = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_cmd   = mem_q[rd_ptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_cmd;
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			if (pop)
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			if (push && !pop)
				count_q <= count_q + QCNT_W'(1);
			else if (pop && !push)
				count_q <= count_q - QCNT_W'(1);
		end
	end

	// The queue is never popped empty nor pushed full.
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("queue popped while empty");
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("queue pushed while full");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCNT_W'(QUEUE_DEPTH))
		else $error("queue count out of range");

endmodule

`default_nettype wire

// ===== rtl/lsp_back.sv =====
// Back end of the line pixel stepper: holds the line state, carries out
// load and step requests, and drives the output register. Uses lsp_pkg.
`default_nettype none

module lsp_back import lsp_pkg::*; (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   head_valid,
	input  wire cmd_t                   head_cmd,
	output logic                        pop,
	output logic                        m_tvalid,
	input  wire logic                   m_tready,
	output logic [OUT_TDATA_W-1:0]      m_tdata,   // pixel_x, pixel_y
	output logic                        m_tlast    // last
);

	logic [COORD_W-1:0]      cur_x_q, cur_y_q, target_x_q, target_y_q, span_x_q;
	logic signed [SPY_W-1:0] span_y_neg_q;
	logic                    step_x_neg_q, step_y_neg_q, active_q;
	logic signed [ERR_W-1:0] err_q;

	logic                    out_valid_q, out_last_q;
	logic [COORD_W-1:0]      out_x_q, out_y_q;

	logic                    out_free, is_load, emit, at_end;
	logic signed [E2_W-1:0]  e2, spy_ext, spx_ext;
	logic                    go_x, go_y;
	logic signed [ERR_W-1:0] err_next;

	// A request is taken when the output register can hold any pixel it makes.
	assign out_free = !out_valid_q || m_tready;
	assign is_load  = (head_cmd.opcode == OP_LOAD);
	assign pop      = head_valid && (is_load || !active_q || out_free);
	assign emit     = pop && !is_load && active_q;

	// Error-term rule for the next pixel.
	assign at_end   = (cur_x_q == target_x_q) && (cur_y_q == target_y_q);
	assign e2       = {err_q, 1'b0};
	assign spy_ext  = {{(E2_W-SPY_W){span_y_neg_q[SPY_W-1]}}, span_y_neg_q};
	assign spx_ext  = {{(E2_W-COORD_W){1'b0}}, span_x_q};
	assign go_x     = (e2 >= spy_ext);
	assign go_y     = (e2 <= spx_ext);
	assign err_next = err_q
		+ (go_x ? ERR_W'(spy_ext) : ERR_W'(0))
		+ (go_y ? ERR_W'(spx_ext) : ERR_W'(0));

	// Line state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_x_q      <= '0;
			cur_y_q      <= '0;
			target_x_q   <= '0;
			target_y_q   <= '0;
			span_x_q     <= '0;
			span_y_neg_q <= '0;
			step_x_neg_q <= 1'b0;
			step_y_neg_q <= 1'b0;
			err_q        <= '0;
			active_q     <= 1'b0;
		end else if (pop && is_load) begin
			cur_x_q      <= head_cmd.start_x;
			cur_y_q      <= head_cmd.start_y;
			target_x_q   <= head_cmd.end_x;
			target_y_q   <= head_cmd.end_y;
			span_x_q     <= head_cmd.span_x;
			span_y_neg_q <= head_cmd.span_y_neg;
			step_x_neg_q <= head_cmd.step_x_neg;
			step_y_neg_q <= head_cmd.step_y_neg;
			err_q        <= head_cmd.err_init;
			active_q     <= 1'b1;
		end else if (emit) begin
			if (at_end) begin
				active_q <= 1'b0;
			end else begin
				err_q <= err_next;
				if (go_x)
					cur_x_q <= step_x_neg_q ? cur_x_q - COORD_W'(1) : cur_x_q + COORD_W'(1);
				if (go_y)
					cur_y_q <= step_y_neg_q ? cur_y_q - COORD_W'(1) : cur_y_q + COORD_W'(1);
			end
		end
	end

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (emit)
			out_valid_q <= 1'b1;
		else if (m_tready)
			out_valid_q <= 1'b0;
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (emit) begin
			out_x_q    <= cur_x_q;
			out_y_q    <= cur_y_q;
			out_last_q <= at_end;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = OUT_TDATA_W'({out_y_q, out_x_q});
	assign m_tlast  = out_last_q;

	// A load always leaves the block active.
	a_load_activates: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && is_load) |=> active_q)
		else $error("load did not activate the line");
	// Emitting the end point closes the line.
	a_last_idles: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && at_end) |=> (!active_q && m_tvalid && m_tlast))
		else $error("end pixel did not close the line");
	// Every emitted pixel shows up at the output next cycle.
	a_emit_shows: assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> m_tvalid)
		else $error("emitted pixel missing at output");
	// A pixel is never emitted over one that is still waiting.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> out_free)
		else $error("output register overwritten");

endmodule

`default_nettype wire
